// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that carries concurrent checks.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: invariant");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`endif

// File: rtl/core/u8js_pkg.sv
// Shared types, constants and helpers for the UTF-8 to JSON string escaper.
// No dependencies; used by all modules of the block.
package u8js_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_U         = 8'h75;

    // How the code point of one job is rendered
    typedef enum logic [2:0] {
        KIND_NONE,  // no code point, quotes only
        KIND_LIT,   // one printable byte
        KIND_ESC,   // backslash plus one byte
        KIND_U1,    // one \uXXXX escape
        KIND_U2     // surrogate pair, two \uXXXX escapes
    } kind_t;

    // One unit of work passed from the decoder to the output sequencer
    typedef struct packed {
        logic        open_q;   // opening quote first
        logic        close_q;  // closing quote last
        kind_t       kind;
        logic [7:0]  ch;       // byte for KIND_LIT / KIND_ESC
        logic [15:0] w0;       // first (or only) escaped word
        logic [15:0] w1;       // low surrogate
    } job_t;

    // Lowercase hex digit for a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'b0, n};
        else
            return 8'h57 + {4'b0, n};
    endfunction

endpackage

// File: rtl/core/u8js_front.sv
// Front end: accepts raw UTF-8 bytes, decodes multibyte sequences and
// classifies each code point into a job. Depends on u8js_pkg.
module u8js_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      in_byte,
    input  logic            string_last,
    input  logic            accept,
    output logic            push,
    output u8js_pkg::job_t  job
);

    logic        in_string_reg, in_string_next;
    logic [1:0]  pending_reg, pending_next;
    logic [20:0] code_reg, code_next;

    logic        emit;
    logic [20:0] ec;
    logic [20:0] code_acc;
    logic [20:0] sup;

    // Decoder state update and code point extraction
    always_comb
    begin
        emit         = 1'b0;
        ec           = '0;
        code_acc     = {code_reg[14:0], in_byte[5:0]};
        pending_next = pending_reg;
        code_next    = code_reg;
        if (pending_reg != 2'd0 && in_byte[7:6] == 2'b10)
        begin
            pending_next = pending_reg - 2'd1;
            code_next    = code_acc;
            if (pending_reg == 2'd1)
            begin
                emit      = 1'b1;
                ec        = code_acc;
                code_next = '0;
            end
        end
        else
        begin
            // fresh byte; a failed continuation drops the partial sequence
            pending_next = 2'd0;
            code_next    = '0;
            if (!in_byte[7])
            begin
                emit = 1'b1;
                ec   = {13'b0, in_byte};
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                code_next    = {16'b0, in_byte[4:0]};
                pending_next = 2'd1;
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                code_next    = {17'b0, in_byte[3:0]};
                pending_next = 2'd2;
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                code_next    = {18'b0, in_byte[2:0]};
                pending_next = 2'd3;
            end
        end
        // final byte: truncated tail dropped, decoder cleared
        if (string_last)
        begin
            pending_next = 2'd0;
            code_next    = '0;
        end
        in_string_next = !string_last;
    end

    // Classify the code point into a job
    always_comb
    begin
        sup         = ec - 21'h010000;
        job.open_q  = !in_string_reg;
        job.close_q = string_last;
        job.kind    = u8js_pkg::KIND_NONE;
        job.ch      = ec[7:0];
        job.w0      = ec[15:0];
        job.w1      = 16'({6'b0, sup[9:0]} + 16'hDC00);
        if (emit)
        begin
            if (ec == {13'b0, u8js_pkg::CH_QUOTE} || ec == {13'b0, u8js_pkg::CH_BACKSLASH})
                job.kind = u8js_pkg::KIND_ESC;
            else if (ec inside {[21'h20:21'h7E]})
                job.kind = u8js_pkg::KIND_LIT;
            else if (ec > 21'h00FFFF)
            begin
                job.kind = u8js_pkg::KIND_U2;
                job.w0   = 16'({5'b0, sup[20:10]} + 16'hD800);
            end
            else
                job.kind = u8js_pkg::KIND_U1;
        end
    end

    // only transactions that produce output characters enter the queue
    assign push = accept && (!in_string_reg || emit || string_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_string_reg <= 1'b0;
            pending_reg   <= 2'd0;
            code_reg      <= '0;
        end
        else if (accept)
        begin
            in_string_reg <= in_string_next;
            pending_reg   <= pending_next;
            code_reg      <= code_next;
        end
    end

endmodule

// File: rtl/core/u8js_queue.sv
// Short job queue between the decoder and the output sequencer.
// Depends on u8js_pkg for the job type.
module u8js_queue
#(
    parameter int DEPTH = u8js_pkg::QUEUE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  u8js_pkg::job_t             push_job,
    input  logic                       pop,
    output logic                       full,
    output logic                       nonempty,
    output u8js_pkg::job_t             head,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u8js_pkg::job_t entry_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];
    assign count    = count_reg;
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - CW'(1);
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: rtl/core/u8js_back.sv
// Back end: expands the job at the queue head into output characters,
// one per cycle unless out_ready stalls the output register. Depends on u8js_pkg.
module u8js_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  u8js_pkg::job_t  job,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_char,
    output logic            run_last,
    output logic            string_closed
);

    logic [3:0] pos_reg;
    logic       valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       closed_reg;

    logic [3:0]  ncode, ntotal, q;
    logic [3:0]  r;
    logic [15:0] w;
    logic [7:0]  code_ch, ch;
    logic        is_last, is_close, advance;

    // number of characters the code point expands to
    always_comb
    begin
        case (job.kind)
            u8js_pkg::KIND_LIT: ncode = 4'd1;
            u8js_pkg::KIND_ESC: ncode = 4'd2;
            u8js_pkg::KIND_U1:  ncode = 4'd6;
            u8js_pkg::KIND_U2:  ncode = 4'd12;
            default:            ncode = 4'd0;
        endcase
    end

    // character at the current position of the job
    always_comb
    begin
        ntotal = {3'b0, job.open_q} + ncode + {3'b0, job.close_q};
        q      = pos_reg - {3'b0, job.open_q};
        if (q >= 4'd6)
        begin
            w = job.w1;
            r = q - 4'd6;
        end
        else
        begin
            w = job.w0;
            r = q;
        end
        case (job.kind)
            u8js_pkg::KIND_LIT: code_ch = job.ch;
            u8js_pkg::KIND_ESC: code_ch = (q == 4'd0) ? u8js_pkg::CH_BACKSLASH : job.ch;
            default:
            begin
                case (r)
                    4'd0:    code_ch = u8js_pkg::CH_BACKSLASH;
                    4'd1:    code_ch = u8js_pkg::CH_U;
                    4'd2:    code_ch = u8js_pkg::hex_char(w[15:12]);
                    4'd3:    code_ch = u8js_pkg::hex_char(w[11:8]);
                    4'd4:    code_ch = u8js_pkg::hex_char(w[7:4]);
                    default: code_ch = u8js_pkg::hex_char(w[3:0]);
                endcase
            end
        endcase
        is_close = 1'b0;
        if (job.open_q && pos_reg == 4'd0)
            ch = u8js_pkg::CH_QUOTE;
        else if (q < ncode)
            ch = code_ch;
        else
        begin
            ch       = u8js_pkg::CH_QUOTE;
            is_close = 1'b1;
        end
        is_last = (pos_reg == ntotal - 4'd1);
    end

    assign advance       = job_valid && (!valid_reg || out_ready);
    assign pop           = advance && is_last;
    assign out_valid     = valid_reg;
    assign out_char      = char_reg;
    assign run_last      = last_reg;
    assign string_closed = closed_reg;

    // position counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
            pos_reg   <= is_last ? 4'd0 : pos_reg + 4'd1;
        end
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            char_reg   <= ch;
            last_reg   <= is_last;
            closed_reg <= is_close;
        end
    end

endmodule

// File: rtl/core/utf8_to_json_string_escaper.sv
// UTF-8 to JSON string-literal escaper, top level.
// Slave stream: s_tdata[7:0] is one raw UTF-8 byte, s_tlast marks the last
// byte of a string. Master stream: m_tdata[7:0] is one character of the
// escaped literal, m_tlast marks the last character caused by one input
// transaction, m_tuser is high on the closing quote.
// Each string is wrapped in quotes; quote and backslash are escaped,
// printable ASCII passes, other code points become \uXXXX (surrogate pairs
// above FFFF). Stray bytes, broken sequences and truncated tails are dropped.
// A transaction's first character is registered in the job queue and then
// in the output register before it can leave.
// Input is accepted one byte per cycle while the job queue (QUEUE_DEPTH
// entries) has room; output runs one character per cycle while m_tready is
// high, and a byte can expand to up to 13 characters.
// Sustained rate is one input per cycle for plain ASCII while m_tready stays
// high; escapes are bounded by the single output port.
// Reset clears the decoder, the queue and the output valid flag; no string is
// open afterwards. When m_tready is low the output register holds, the queue
// fills, and s_tready drops once it is full.
`include "assert_macros.svh"

module utf8_to_json_string_escaper
#(
    parameter int QUEUE_DEPTH = u8js_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // string_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // [0] string_closed
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    u8js_pkg::job_t front_job, head_job;
    logic           accept, push, pop, q_full, q_nonempty;
    logic [CW-1:0]  q_count;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    u8js_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (s_tdata),
        .string_last (s_tlast),
        .accept      (accept),
        .push        (push),
        .job         (front_job)
    );

    u8js_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .pop      (pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (head_job),
        .count    (q_count)
    );

    u8js_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (q_nonempty),
        .job           (head_job),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_char      (m_tdata),
        .run_last      (m_tlast),
        .string_closed (m_tuser)
    );

    // closing quote always ends the run of its transaction
    `ASSERT_IMPLIES(a_close_is_last, clk, rst_n, m_tvalid && m_tuser, m_tlast)
    // closing flag only ever marks a quote character
    `ASSERT_IMPLIES(a_close_is_quote, clk, rst_n, m_tvalid && m_tuser, m_tdata == u8js_pkg::CH_QUOTE)
    // queue fill never exceeds its depth
    `ASSERT_ALWAYS(a_queue_bound, clk, rst_n, q_count <= CW'(QUEUE_DEPTH))

endmodule
